### rtl/hbp_pkg.sv
// shared types and constants of the variable-length code bit packer
// no dependencies; imported by hbp_merge, hbp_out_queue and huffman_bit_packer_unit
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

    localparam int NUM_CODES   = 4;
    localparam int CODE_BITS   = 16;
    localparam int LEN_BITS    = 5;
    localparam int LINE_BITS   = 128;
    localparam int LINE_IDX_W  = 7;     // bit index inside one line
    localparam int OFF_W       = 8;     // offset inside the two-line merge window
    localparam int POS_BITS    = 32;
    localparam int BYTES_BITS  = 30;

    localparam logic [LEN_BITS-1:0] CODE_MAX = LEN_BITS'(CODE_BITS);

    localparam logic CMD_CODES  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 160;

    // one accepted input item
    typedef struct packed {
        logic                               cmd;
        logic [NUM_CODES-1:0][CODE_BITS-1:0] code;
        logic [NUM_CODES-1:0][LEN_BITS-1:0]  len;
    } item_t;

    // everything one input item sends toward the output side
    typedef struct packed {
        logic [LINE_BITS-1:0]  line;
        logic                  has_line;
        logic                  has_size;
        logic [BYTES_BITS-1:0] bytes;
    } entry_t;

endpackage

`default_nettype wire

### rtl/hbp_merge.sv
// merge datapath: places up to four codes into the partial line, handles finish
// depends on hbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbp_merge (
    input  wire  hbp_pkg::item_t                       item,
    input  wire  logic [hbp_pkg::LINE_BITS-1:0]         partial_line,
    input  wire  logic [hbp_pkg::POS_BITS-1:0]          bit_position,
    output hbp_pkg::entry_t                             entry,
    output logic                                        entry_push,
    output logic [hbp_pkg::LINE_BITS-1:0]               partial_line_next,
    output logic [hbp_pkg::POS_BITS-1:0]                bit_position_next
);
    import hbp_pkg::*;

    logic [2*LINE_BITS-1:0] window;
    logic [OFF_W-1:0]       off;
    logic [OFF_W-1:0]       start;
    logic [LEN_BITS-1:0]    sat_len;
    logic [CODE_BITS:0]     mask;
    logic [CODE_BITS-1:0]   masked;
    logic [POS_BITS:0]      pos_round;

    always_comb
    begin
        start  = {1'b0, bit_position[LINE_IDX_W-1:0]};
        off    = start;
        window = {{LINE_BITS{1'b0}}, partial_line};
        for (int i = 0; i < NUM_CODES; i++)
        begin
            sat_len = (item.len[i] > CODE_MAX) ? CODE_MAX : item.len[i];
            mask    = ((CODE_BITS+1)'(1) << sat_len) - (CODE_BITS+1)'(1);
            masked  = item.code[i] & mask[CODE_BITS-1:0];
            window  = window | ((2*LINE_BITS)'(masked) << off);
            off     = off + OFF_W'(sat_len);
        end

        pos_round = {1'b0, bit_position} + (POS_BITS+1)'(7);

        entry             = '0;
        entry_push        = 1'b0;
        partial_line_next = partial_line;
        bit_position_next = bit_position;

        case (item.cmd)
            CMD_FINISH:
            begin
                // flush a non-empty line, then the byte count
                entry.line        = partial_line;
                entry.has_line    = (bit_position[LINE_IDX_W-1:0] != '0);
                entry.has_size    = 1'b1;
                entry.bytes       = pos_round[POS_BITS:3];
                entry_push        = 1'b1;
                partial_line_next = '0;
                bit_position_next = '0;
            end
            CMD_CODES:
            begin
                bit_position_next = bit_position + POS_BITS'(off - start);
                entry.line        = window[LINE_BITS-1:0];
                entry.has_line    = off[OFF_W-1];
                entry_push        = off[OFF_W-1];
                partial_line_next = off[OFF_W-1] ? window[2*LINE_BITS-1:LINE_BITS]
                                                 : window[LINE_BITS-1:0];
            end
            default:
            begin
                entry_push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/hbp_out_queue.sv
// two-entry result queue; one entry may carry a data line and a size marker
// depends on hbp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbp_out_queue (
    input  wire  logic                               clk,
    input  wire  logic                               rst_n,
    input  wire  logic                               push,
    input  wire  hbp_pkg::entry_t                    push_entry,
    output logic                                     full,
    output logic                                     m_tvalid,
    input  wire  logic                               m_tready,
    output logic [hbp_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic                                     m_tuser,
    output logic                                     m_tlast
);
    import hbp_pkg::*;

    entry_t       entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         phase_reg, phase_next;
    entry_t       head;
    logic         emit_size;
    logic         xfer;
    logic         pop;

    assign head      = entry_reg[rd_ptr_reg];
    assign emit_size = !head.has_line || phase_reg;
    assign full      = (count_reg == 2'd2);
    assign m_tvalid  = (count_reg != 2'd0);
    assign m_tuser   = emit_size;
    assign m_tlast   = emit_size || !head.has_size;
    assign m_tdata   = emit_size
                     ? {{(M_TDATA_W-LINE_BITS-BYTES_BITS){1'b0}}, head.bytes,
                        {LINE_BITS{1'b0}}}
                     : {{(M_TDATA_W-LINE_BITS){1'b0}}, head.line};
    assign xfer      = m_tvalid && m_tready;
    assign pop       = xfer && m_tlast;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
        phase_next  = pop ? 1'b0 : (xfer ? 1'b1 : phase_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### rtl/huffman_bit_packer_unit.sv
// top level of the variable-length code bit packer
// depends on hbp_pkg, hbp_merge and hbp_out_queue
`timescale 1ns / 1ps
`default_nettype none

// packs groups of up to four variable-length codes (lsb first) into 128-bit
// lines. one input transfer is taken per cycle unless a held item waits on a
// full queue: the item lands in an input register, the merge logic places its
// codes in one pass and the outcome is written to a two-entry result queue,
// so an item leaves the input register the cycle after it arrives unless the
// queue is full. a code item yields one output transfer when its line fills
// and none otherwise; a finish item yields the flushed partial line (tlast
// low, only if it holds bits) and then the size marker (tuser high, tlast
// high) carrying ceil(bits/8). the output port moves one transfer per cycle
// while m_tready is high, so the sustained rate is one item per cycle with a
// ready sink, and a finish item that flushes a line costs one extra output
// transfer. code lengths above 16 saturate to 16 and code bits above the
// length are ignored; the bit position wraps at 2^32.
module huffman_bit_packer_unit (
    input  wire  logic                            clk,
    input  wire  logic                            rst_n,
    input  wire  logic                            s_tvalid,
    output logic                                  s_tready,
    // code_a, code_b, code_c, code_d, len_a, len_b, len_c, len_d, zero pad
    input  wire  logic [hbp_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  wire  logic                            s_tuser,
    output logic                                  m_tvalid,
    input  wire  logic                            m_tready,
    // word_low, word_high, total_bytes, zero pad
    output logic [hbp_pkg::M_TDATA_W-1:0]         m_tdata,
    // is_size
    output logic                                  m_tuser,
    output logic                                  m_tlast
);
    import hbp_pkg::*;

    // input register
    logic                  in_valid_reg, in_valid_next;
    item_t                 in_item_reg;
    item_t                 s_item;

    // packer state
    logic [LINE_BITS-1:0]  partial_line_reg, partial_line_next;
    logic [POS_BITS-1:0]   bit_position_reg, bit_position_next;

    entry_t                entry;
    logic                  entry_push;
    logic                  q_full;
    logic                  process;
    logic                  s_xfer;

    // unpack the slave transfer into an item
    always_comb
    begin
        s_item.cmd = s_tuser;
        for (int i = 0; i < NUM_CODES; i++)
        begin
            s_item.code[i] = s_tdata[i*CODE_BITS +: CODE_BITS];
            s_item.len[i]  = s_tdata[NUM_CODES*CODE_BITS + i*LEN_BITS +: LEN_BITS];
        end
    end

    // the held item is merged whenever the queue has a free entry
    assign process  = in_valid_reg && !q_full;
    assign s_tready = !in_valid_reg || process;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = s_xfer ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    end

    hbp_merge u_merge (
        .item              (in_item_reg),
        .partial_line      (partial_line_reg),
        .bit_position      (bit_position_reg),
        .entry             (entry),
        .entry_push        (entry_push),
        .partial_line_next (partial_line_next),
        .bit_position_next (bit_position_next)
    );

    hbp_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (process && entry_push),
        .push_entry (entry),
        .full       (q_full),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            partial_line_reg <= '0;
            bit_position_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (process)
            begin
                partial_line_reg <= partial_line_next;
                bit_position_reg <= bit_position_next;
            end
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire
